// ===== design/bebt_pkg.sv =====
// Shared types, codes and constants of the band energy beat trigger.
`default_nettype none
package bebt_pkg;

	localparam int BANDS_DEF   = 64;
	localparam int HISTORY_DEF = 10;

	localparam int LEVEL_W = 16;
	localparam int MS_W    = 10;
	localparam int COUNT_W = 8;
	localparam int RULE_W  = 3;
	localparam int BANDIX_W = 8;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TREBLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS   = 3'd6;

	localparam logic [15:0] BASS_RST    = 16'd9830;
	localparam logic [15:0] MID_RST     = 16'd13107;
	localparam logic [15:0] TREBLE_RST  = 16'd11469;
	localparam logic [15:0] SPIKE_RST   = 16'd16384;
	localparam logic [15:0] SUSTAIN_RST = 16'd19661;
	localparam logic [15:0] PEAK_RST    = 16'd13107;
	localparam logic [7:0]  SLOTS_RST   = 8'd16;

	// rule codes
	localparam logic [RULE_W-1:0] RULE_NONE    = 3'd0;
	localparam logic [RULE_W-1:0] RULE_BASS    = 3'd1;
	localparam logic [RULE_W-1:0] RULE_MID     = 3'd2;
	localparam logic [RULE_W-1:0] RULE_TREBLE  = 3'd3;
	localparam logic [RULE_W-1:0] RULE_SPIKE   = 3'd4;
	localparam logic [RULE_W-1:0] RULE_SUSTAIN = 3'd5;

	// 0.01 in Q1.15, ratio thresholds times ten
	localparam int EPS_Q15 = 328;
	localparam int K_BASS  = 20;
	localparam int K_MID   = 18;
	localparam int K_TREB  = 16;
	localparam int K_SPIKE = 25;

	// hold-off limits in ms
	localparam logic [15:0] HOLD_BASS    = 16'd300;
	localparam logic [15:0] HOLD_MID     = 16'd400;
	localparam logic [15:0] HOLD_TREB    = 16'd600;
	localparam logic [15:0] HOLD_SPIKE   = 16'd200;
	localparam logic [15:0] HOLD_SUSTAIN = 16'd1000;

	// exact reciprocal division: sum of three averages by 3, 4*total by 5
	localparam int ESUM_W      = 18;
	localparam int THREE_SHIFT = 20;
	localparam longint unsigned THREE_MUL = ((64'd1 << THREE_SHIFT) + 64'd2) / 64'd3;
	localparam int MUL3_W      = 20;
	localparam int FIVE_SHIFT  = 21;
	localparam longint unsigned FIVE_MUL = ((64'd1 << FIVE_SHIFT) + 64'd4) / 64'd5;
	localparam int MUL5_W      = 20;

	typedef struct packed {
		logic [LEVEL_W-1:0]  peak_v;
		logic [BANDIX_W-1:0] peak_b;
		logic [MS_W-1:0]     ms;
		logic [COUNT_W-1:0]  act;
	} ctx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] bass;
		logic [LEVEL_W-1:0] mid;
		logic [LEVEL_W-1:0] treb;
		logic [LEVEL_W-1:0] total;
	} avg_t;

	typedef struct packed {
		logic bass_hi;
		logic mid_hi;
		logic treb_hi;
		logic spike_hi;
		logic sust_hi;
		logic peak_hi;
		logic beat_bass;
		logic beat_mid;
		logic beat_treb;
		logic beat_spike;
		logic slot1;
		logic slot2;
		logic slot3;
	} flags_t;

	typedef struct packed {
		logic [RULE_W-1:0]   rule;
		logic [LEVEL_W-1:0]  i1;
		logic [BANDIX_W-1:0] b1;
		logic [LEVEL_W-1:0]  i2;
		logic [BANDIX_W-1:0] b2;
		logic [LEVEL_W-1:0]  energy;
	} res_t;

endpackage
`default_nettype wire

// ===== design/band_energy_beat_trigger.sv =====
// Top level of the band energy beat trigger: band accumulation, frame pipeline, history ring.
`default_nettype none
// One band magnitude is taken every cycle; a frame is BANDS transfers. The last band of
// a frame enters a nine-stage frame pipeline (three reciprocal multiplies for the
// averages, one for the total, history compare, rule decision), whose last stage s9
// writes the frame's result into the two-entry output queue. The history of totals
// sits in a HISTORY_DEPTH-entry ring memory, read and written back once per frame;
// per-entry valid flags make it read as zero after reset, with no clearing pass.
// Bands that close no frame are always taken; the last band of a frame waits only
// while two finished or in-flight frames are still unread downstream.
module band_energy_beat_trigger
	import bebt_pkg::*;
#(
	parameter int BANDS         = BANDS_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [15:0] band_level, [25:16] frame_ms, [33:26] active_count, [39:34] zero
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [15:0] first_intensity, [23:16] first_band, [39:24] second_intensity,
	// [47:40] second_band, [63:48] frame_energy
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// [2:0] rule_fired
	output logic [RULE_W-1:0]          m_tuser
);

	localparam int NB    = BANDS / 3;
	localparam int NT    = BANDS - 2 * NB;
	localparam int BandW = $clog2(BANDS);
	localparam int SumW  = LEVEL_W + BandW;
	localparam int MulW  = SumW + 2;
	localparam int ProdW = SumW + MulW;
	localparam int BassS = SumW + $clog2(NB);
	localparam int TrebS = SumW + $clog2(NT);
	localparam longint unsigned BassM = ((64'd1 << BassS) + 64'(NB) - 64'd1) / 64'(NB);
	localparam longint unsigned TrebM = ((64'd1 << TrebS) + 64'(NT) - 64'd1) / 64'(NT);
	localparam int PtrW  = $clog2(HISTORY_DEPTH);
	localparam int RtW   = LEVEL_W + $clog2(HISTORY_DEPTH);
	localparam int BaseW = RtW + 1;
	localparam int CmpW  = BaseW + 5;
	localparam logic [BANDIX_W-1:0] BandMid  = BANDIX_W'(BANDS / 2);
	localparam logic [BANDIX_W-1:0] BandTop  = BANDIX_W'(BANDS - 1);
	localparam logic [BANDIX_W-1:0] BandSpk  = BANDIX_W'(NB);
	localparam logic [BANDIX_W-1:0] BandSpk2 = BANDIX_W'(NB + NB / 2);

	// configuration
	logic [15:0] bass_lvl_q, mid_lvl_q, treb_lvl_q, spike_lvl_q, sust_lvl_q, peak_lvl_q;
	logic [7:0]  slots_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bass_lvl_q  <= BASS_RST;
			mid_lvl_q   <= MID_RST;
			treb_lvl_q  <= TREBLE_RST;
			spike_lvl_q <= SPIKE_RST;
			sust_lvl_q  <= SUSTAIN_RST;
			peak_lvl_q  <= PEAK_RST;
			slots_q     <= SLOTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASS:    bass_lvl_q  <= cfg_data;
				REG_MID:     mid_lvl_q   <= cfg_data;
				REG_TREBLE:  treb_lvl_q  <= cfg_data;
				REG_SPIKE:   spike_lvl_q <= cfg_data;
				REG_SUSTAIN: sust_lvl_q  <= cfg_data;
				REG_PEAK:    peak_lvl_q  <= cfg_data;
				REG_SLOTS:   slots_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// band accumulation
	logic [BandW-1:0]   band_cnt_q;
	logic [SumW-1:0]    bass_q, mid_q, treb_q;
	logic [LEVEL_W-1:0] peak_v_q;
	logic [BandW-1:0]   peak_b_q;
	logic [1:0]         pend_q;

	logic [LEVEL_W-1:0] level;
	logic               in_xfer, last_band, in_bass, in_mid, new_peak;
	logic [SumW-1:0]    bass_nx, mid_nx, treb_nx;
	logic [LEVEL_W-1:0] peak_v_nx;
	logic [BandW-1:0]   peak_b_nx;
	logic               out_xfer;

	assign level     = s_tdata[15:0];
	assign last_band = band_cnt_q == BandW'(BANDS - 1);
	assign s_tready  = !(last_band && pend_q == 2'd2);
	assign in_xfer   = s_tvalid && s_tready;
	assign in_bass   = band_cnt_q < BandW'(NB);
	assign in_mid    = !in_bass && band_cnt_q < BandW'(2 * NB);
	assign new_peak  = level > peak_v_q;

	always_comb begin
		bass_nx   = bass_q + ((in_bass) ? SumW'(level) : '0);
		mid_nx    = mid_q + ((in_mid) ? SumW'(level) : '0);
		treb_nx   = treb_q + ((!in_bass && !in_mid) ? SumW'(level) : '0);
		peak_v_nx = new_peak ? level : peak_v_q;
		peak_b_nx = new_peak ? band_cnt_q : peak_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_cnt_q <= '0;
			bass_q     <= '0;
			mid_q      <= '0;
			treb_q     <= '0;
			peak_v_q   <= '0;
			peak_b_q   <= '0;
		end else if (in_xfer) begin
			if (last_band) begin
				band_cnt_q <= '0;
				bass_q     <= '0;
				mid_q      <= '0;
				treb_q     <= '0;
				peak_v_q   <= '0;
				peak_b_q   <= '0;
			end else begin
				band_cnt_q <= band_cnt_q + BandW'(1);
				bass_q     <= bass_nx;
				mid_q      <= mid_nx;
				treb_q     <= treb_nx;
				peak_v_q   <= peak_v_nx;
				peak_b_q   <= peak_b_nx;
			end
		end
	end

	// frames in the pipeline plus results waiting in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_xfer && last_band, out_xfer})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// frame pipeline
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
		end else begin
			vld_s1 <= in_xfer && last_band;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	logic [SumW-1:0]    bass_s1, mid_s1, mid_s2, treb_s1, treb_s2, treb_s3;
	ctx_t               ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9;
	avg_t               avg_s2, avg_s3, avg_s4, avg_s5, avg_s6, avg_s7, avg_s8, avg_s9;
	logic [ESUM_W-1:0]  esum_s5;
	logic [LEVEL_W-1:0] ring_rd_s6;
	logic               ring_hit_s6;
	logic [CmpW-1:0]    lhs_s7, lhs_s8;
	logic [BaseW-1:0]   base_s7;
	logic [CmpW-1:0]    rb_s8, rm_s8, rt_s8, rs_s8;
	flags_t             flg_s8, flg_s9;
	logic [LEVEL_W-1:0] i2_s9;

	logic [ProdW-1:0]               bass_prod, mid_prod, treb_prod;
	logic [ESUM_W+MUL3_W-1:0]       three_prod;
	logic [ESUM_W+MUL5_W-1:0]       five_prod;
	logic [LEVEL_W-1:0]             total_s6;
	logic [LEVEL_W-1:0]             ring_old;

	assign bass_prod  = ProdW'(bass_s1) * ProdW'(BassM);
	assign mid_prod   = ProdW'(mid_s2) * ProdW'(BassM);
	assign treb_prod  = ProdW'(treb_s3) * ProdW'(TrebM);
	assign three_prod = (ESUM_W + MUL3_W)'(esum_s5) * (ESUM_W + MUL3_W)'(THREE_MUL);
	assign five_prod  = (ESUM_W + MUL5_W)'({avg_s8.total, 2'b00}) * (ESUM_W + MUL5_W)'(FIVE_MUL);
	assign total_s6   = avg_s6.total;
	assign ring_old   = ring_hit_s6 ? ring_rd_s6 : '0;

	always_ff @(posedge clk) begin
		if (in_xfer && last_band) begin
			bass_s1       <= bass_nx;
			mid_s1        <= mid_nx;
			treb_s1       <= treb_nx;
			ctx_s1.peak_v <= peak_v_nx;
			ctx_s1.peak_b <= BANDIX_W'(peak_b_nx);
			ctx_s1.ms     <= s_tdata[25:16];
			ctx_s1.act    <= s_tdata[33:26];
		end
		avg_s2      <= '0;
		avg_s2.bass <= bass_prod[BassS +: LEVEL_W];
		mid_s2      <= mid_s1;
		treb_s2     <= treb_s1;
		ctx_s2      <= ctx_s1;

		avg_s3      <= avg_s2;
		avg_s3.mid  <= mid_prod[BassS +: LEVEL_W];
		treb_s3     <= treb_s2;
		ctx_s3      <= ctx_s2;

		avg_s4      <= avg_s3;
		avg_s4.treb <= treb_prod[TrebS +: LEVEL_W];
		ctx_s4      <= ctx_s3;

		avg_s5  <= avg_s4;
		esum_s5 <= ESUM_W'(avg_s4.bass) + ESUM_W'(avg_s4.mid) + ESUM_W'(avg_s4.treb);
		ctx_s5  <= ctx_s4;

		avg_s6       <= avg_s5;
		avg_s6.total <= three_prod[THREE_SHIFT +: LEVEL_W];
		ctx_s6       <= ctx_s5;

		avg_s7  <= avg_s6;
		ctx_s7  <= ctx_s6;
		lhs_s7  <= CmpW'(total_s6) * CmpW'(HISTORY_DEPTH * 10);
		base_s7 <= BaseW'(ring_total_q) + BaseW'(EPS_Q15 * HISTORY_DEPTH);

		avg_s8  <= avg_s7;
		ctx_s8  <= ctx_s7;
		lhs_s8  <= lhs_s7;
		rb_s8   <= CmpW'(base_s7) * CmpW'(K_BASS);
		rm_s8   <= CmpW'(base_s7) * CmpW'(K_MID);
		rt_s8   <= CmpW'(base_s7) * CmpW'(K_TREB);
		rs_s8   <= CmpW'(base_s7) * CmpW'(K_SPIKE);
		flg_s8          <= '0;
		flg_s8.bass_hi  <= avg_s7.bass > bass_lvl_q;
		flg_s8.mid_hi   <= avg_s7.mid > mid_lvl_q;
		flg_s8.treb_hi  <= avg_s7.treb > treb_lvl_q;
		flg_s8.spike_hi <= avg_s7.total > spike_lvl_q;
		flg_s8.sust_hi  <= avg_s7.total > sust_lvl_q;
		flg_s8.peak_hi  <= ctx_s7.peak_v > peak_lvl_q;

		avg_s9  <= avg_s8;
		ctx_s9  <= ctx_s8;
		i2_s9   <= five_prod[FIVE_SHIFT +: LEVEL_W];
		flg_s9            <= flg_s8;
		flg_s9.beat_bass  <= lhs_s8 > rb_s8;
		flg_s9.beat_mid   <= lhs_s8 > rm_s8;
		flg_s9.beat_treb  <= lhs_s8 > rt_s8;
		flg_s9.beat_spike <= lhs_s8 > rs_s8;
		// signed gate active < cap - margin, written without a sign
		flg_s9.slot1 <= (9'(ctx_s8.act) + 9'd1) < 9'(slots_q);
		flg_s9.slot2 <= (9'(ctx_s8.act) + 9'd2) < 9'(slots_q);
		flg_s9.slot3 <= (9'(ctx_s8.act) + 9'd3) < 9'(slots_q);
	end

	// history ring: read at s5, written back at s6
	logic [LEVEL_W-1:0]       ring_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] ring_vld_q;
	logic [PtrW-1:0]          ring_ptr_q;
	logic [RtW-1:0]           ring_total_q;

	always_ff @(posedge clk) begin
		if (vld_s5) begin
			ring_rd_s6  <= ring_mem[ring_ptr_q];
			ring_hit_s6 <= ring_vld_q[ring_ptr_q];
		end
		if (vld_s6) begin
			ring_mem[ring_ptr_q] <= total_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q   <= '0;
			ring_ptr_q   <= '0;
			ring_total_q <= '0;
		end else if (vld_s6) begin
			ring_vld_q[ring_ptr_q] <= 1'b1;
			ring_total_q <= ring_total_q - RtW'(ring_old) + RtW'(total_s6);
			ring_ptr_q   <= (ring_ptr_q == PtrW'(HISTORY_DEPTH - 1)) ? '0
				: ring_ptr_q + PtrW'(1);
		end
	end

	// rule decision and hold-off timer
	logic [15:0] timer_q;
	logic [16:0] tsum;
	logic [15:0] tnow;
	res_t        res;

	assign tsum = {1'b0, timer_q} + 17'(ctx_s9.ms);
	assign tnow = tsum[16] ? 16'hFFFF : tsum[15:0];

	always_comb begin
		res        = '0;
		res.rule   = RULE_NONE;
		res.energy = avg_s9.total;
		if (flg_s9.bass_hi && flg_s9.beat_bass && tnow > HOLD_BASS && flg_s9.slot1) begin
			res.rule = RULE_BASS;
			res.i1   = avg_s9.bass;
		end else if (flg_s9.mid_hi && flg_s9.beat_mid && tnow > HOLD_MID && flg_s9.slot1) begin
			res.rule = RULE_MID;
			res.i1   = avg_s9.mid;
			res.b1   = BandMid;
		end else if (flg_s9.treb_hi && flg_s9.beat_treb && tnow > HOLD_TREB
				&& flg_s9.slot1) begin
			res.rule = RULE_TREBLE;
			res.i1   = avg_s9.treb;
			res.b1   = BandTop;
		end else if (flg_s9.spike_hi && flg_s9.beat_spike && tnow > HOLD_SPIKE
				&& flg_s9.slot2) begin
			res.rule = RULE_SPIKE;
			res.i1   = avg_s9.total;
			res.b1   = BandSpk;
			res.i2   = i2_s9;
			res.b2   = BandSpk2;
		end else if (flg_s9.sust_hi && tnow > HOLD_SUSTAIN && flg_s9.slot3) begin
			// weak peak: no trigger and the timer runs on
			if (flg_s9.peak_hi) begin
				res.rule = RULE_SUSTAIN;
				res.i1   = ctx_s9.peak_v;
				res.b1   = ctx_s9.peak_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (vld_s9) begin
			timer_q <= (res.rule != RULE_NONE) ? '0 : tnow;
		end
	end

	// output queue
	res_t       oq_q [2];
	logic       oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	res_t       head;

	assign m_tvalid = oq_cnt_q != 2'd0;
	assign out_xfer = m_tvalid && m_tready;
	assign head     = oq_q[oq_rd_q];
	assign m_tuser  = head.rule;
	assign m_tdata  = {head.energy, head.b2, head.i2, head.b1, head.i1};

	always_ff @(posedge clk) begin
		if (vld_s9) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (vld_s9) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (out_xfer) begin
				oq_rd_q <= !oq_rd_q;
			end
			case ({vld_s9, out_xfer})
				2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/bebt_checker.sv =====
// Port-level checks of the band energy beat trigger, bound to the top level.
`default_nettype none
module bebt_checker
	import bebt_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [IN_DATA_W-1:0]  s_tdata,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [RULE_W-1:0]     m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no trigger: both trigger slots are empty
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RULE_NONE |-> m_tdata[47:0] == 48'd0)
		else $error("idle frame carries trigger data");

	// second trigger only with the volume spike
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != RULE_SPIKE |-> m_tdata[47:24] == 24'd0)
		else $error("second trigger outside volume spike");

	// volume spike reports the frame energy as its intensity
	a_spike: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RULE_SPIKE |-> m_tdata[15:0] == m_tdata[63:48])
		else $error("spike intensity differs from frame energy");

endmodule

bind band_energy_beat_trigger bebt_checker u_bebt_checker (.*);
`default_nettype wire
